@@ rtl/core/ils_pkg.sv @@
// ils_pkg: shared widths and operation codes of the indexed list store
`timescale 1ns / 1ps

package ils_pkg;

  // payload widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 7;

  // request operation codes
  typedef enum logic [FUNC_W-1:0] {
    OP_READ = 3'd0,
    OP_HEAD = 3'd1,
    OP_TAIL = 3'd2,
    OP_AT   = 3'd3,
    OP_DEL  = 3'd4
  } func_e;

  // value returned when no read hit
  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

endpackage

@@ rtl/core/ils_if.sv @@
// ils_req_if, ils_rsp_if: request and response channels of the indexed list store
`timescale 1ns / 1ps

interface ils_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [ils_pkg::FUNC_W-1:0]       func;
  logic signed [ils_pkg::POS_W-1:0]        position;
  logic signed [ils_pkg::VALUE_W-1:0]      item_value;

  modport source (output valid, func, position, item_value, input ready);
  modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface ils_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ils_pkg::VALUE_W-1:0]      read_value;
  logic                                    found;
  logic                                    applied;
  logic                                    full_drop;
  logic        [ils_pkg::LEN_W-1:0]        list_length;

  modport source (output valid, read_value, found, applied, full_drop, list_length,
                  input ready);
  modport sink   (input valid, read_value, found, applied, full_drop, list_length,
                  output ready);
endinterface

@@ rtl/core/indexed_list_store_top.sv @@
// indexed_list_store_top: ordered list of signed values in a memory with a length counter
// Flow: one transaction at a time; the shift loop moves one entry through a read state and
//   a write state of the single-port-read, single-port-write memory.
// Reset: asynchronous, active low; clears the length and the sequencer, memory contents
//   stay undefined and are never read before being written.
`timescale 1ns / 1ps

module indexed_list_store_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ils_req_if.sink   req_i,
  ils_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W  = (CNT_W > ils_pkg::POS_W - 1) ? CNT_W : ils_pkg::POS_W - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_RESP
  } state_e;

  state_e                              state_q;
  logic [CNT_W-1:0]                    count_q;
  logic [ADDR_W-1:0]                   ptr_q;
  logic [ADDR_W-1:0]                   tgt_q;
  logic [ils_pkg::VALUE_W-1:0]         val_q;
  logic [ils_pkg::VALUE_W-1:0]         res_value_q;
  logic                                res_found_q;
  logic                                res_applied_q;
  logic                                res_drop_q;

  logic                                out_valid_q;
  logic [ils_pkg::VALUE_W-1:0]         out_value_q;
  logic                                out_found_q;
  logic                                out_applied_q;
  logic                                out_drop_q;
  logic [ils_pkg::LEN_W-1:0]           out_len_q;

  // memory
  logic [ils_pkg::VALUE_W-1:0]         mem [CAPACITY];
  logic [ils_pkg::VALUE_W-1:0]         rd_data_q;
  logic                                mem_we;
  logic [ADDR_W-1:0]                   mem_waddr;
  logic [ils_pkg::VALUE_W-1:0]         mem_wdata;
  logic                                mem_re;
  logic [ADDR_W-1:0]                   mem_raddr;

  // request decode
  logic                                accept;
  logic                                pos_neg;
  logic [CMP_W-1:0]                    pos_ext;
  logic [CMP_W-1:0]                    cnt_ext;
  logic                                pos_lt_cnt;
  logic                                pos_le_cnt;
  logic                                full;
  logic                                ins_go;
  logic [ADDR_W-1:0]                   ins_tgt;
  logic                                read_hit;
  logic                                out_free;
  logic                                ptr_at_tgt;
  logic                                del_last;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign pos_neg    = req_i.position[ils_pkg::POS_W-1];
  assign pos_ext    = CMP_W'(req_i.position[ils_pkg::POS_W-2:0]);
  assign cnt_ext    = CMP_W'(count_q);
  assign pos_lt_cnt = !pos_neg && (pos_ext < cnt_ext);
  assign pos_le_cnt = !pos_neg && (pos_ext <= cnt_ext);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign read_hit   = pos_lt_cnt;

  assign ptr_at_tgt = (ptr_q == tgt_q);
  assign del_last   = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);

  // insert target and whether the insert applies at all
  always_comb begin
    ins_go  = 1'b0;
    ins_tgt = '0;
    case (ils_pkg::func_e'(req_i.func))
      ils_pkg::OP_HEAD: begin
        ins_go = 1'b1;
      end
      ils_pkg::OP_TAIL: begin
        ins_go  = 1'b1;
        ins_tgt = ADDR_W'(count_q);
      end
      ils_pkg::OP_AT: begin
        if (pos_neg) begin
          ins_go = 1'b1;
        end else if (pos_le_cnt) begin
          ins_go  = 1'b1;
          ins_tgt = ADDR_W'(pos_ext);
        end
      end
      default: begin
        ins_go = 1'b0;
      end
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = rd_data_q;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (ils_pkg::func_e'(req_i.func) == ils_pkg::OP_READ) && read_hit) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(pos_ext);
        end
      end
      ST_INS_RD: begin
        if (ptr_at_tgt) begin
          mem_we    = 1'b1;
          mem_waddr = tgt_q;
          mem_wdata = val_q;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - ADDR_W'(1);
        end
      end
      ST_INS_WR: begin
        mem_we = 1'b1;
      end
      ST_DEL_RD: begin
        if (!del_last) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + ADDR_W'(1);
        end
      end
      ST_DEL_WR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // memory registered read port
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // sequencer, length counter and response registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // response taken and no new one loaded this cycle
      if (out_valid_q && rsp_o.ready && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_value_q   <= ils_pkg::MISS_VALUE;
            res_found_q   <= 1'b0;
            res_applied_q <= 1'b0;
            res_drop_q    <= ins_go && full;
            val_q         <= req_i.item_value;
            tgt_q         <= ins_tgt;
            ptr_q         <= (ils_pkg::func_e'(req_i.func) == ils_pkg::OP_DEL) ?
                             ADDR_W'(pos_ext) : ADDR_W'(count_q);
            case (ils_pkg::func_e'(req_i.func))
              ils_pkg::OP_READ: begin
                state_q <= read_hit ? ST_RD_WAIT : ST_RESP;
              end
              ils_pkg::OP_HEAD, ils_pkg::OP_TAIL, ils_pkg::OP_AT: begin
                state_q <= (ins_go && !full) ? ST_INS_RD : ST_RESP;
              end
              ils_pkg::OP_DEL: begin
                state_q <= pos_lt_cnt ? ST_DEL_RD : ST_RESP;
              end
              default: begin
                state_q <= ST_RESP;
              end
            endcase
          end
        end
        ST_RD_WAIT: begin
          res_value_q <= rd_data_q;
          res_found_q <= 1'b1;
          state_q     <= ST_RESP;
        end
        ST_INS_RD: begin
          // place the new value once the tail has been shifted up to the target
          if (ptr_at_tgt) begin
            count_q       <= count_q + CNT_W'(1);
            res_applied_q <= 1'b1;
            state_q       <= ST_RESP;
          end else begin
            state_q <= ST_INS_WR;
          end
        end
        ST_INS_WR: begin
          ptr_q   <= ptr_q - ADDR_W'(1);
          state_q <= ST_INS_RD;
        end
        ST_DEL_RD: begin
          // close the gap one entry at a time until the last entry
          if (del_last) begin
            count_q       <= count_q - CNT_W'(1);
            res_applied_q <= 1'b1;
            state_q       <= ST_RESP;
          end else begin
            state_q <= ST_DEL_WR;
          end
        end
        ST_DEL_WR: begin
          ptr_q   <= ptr_q + ADDR_W'(1);
          state_q <= ST_DEL_RD;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_value_q   <= res_value_q;
            out_found_q   <= res_found_q;
            out_applied_q <= res_applied_q;
            out_drop_q    <= res_drop_q;
            out_len_q     <= ils_pkg::LEN_W'(count_q);
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // response channel
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.found       = out_found_q;
  assign rsp_o.applied     = out_applied_q;
  assign rsp_o.full_drop   = out_drop_q;
  assign rsp_o.list_length = out_len_q;

endmodule
